// ===== hdl/m4v_pkg.sv =====
// m4v_pkg: shared types, constants and float32 unpack helper for the
// 4x4 matrix-vector transform. No dependencies.
package m4v_pkg;

  localparam int FW      = 32;          // float32 width
  localparam int NW      = 48;          // normaliser significand width
  localparam int EW      = 12;          // signed working exponent width
  localparam int NREG    = 8;           // matrix registers
  localparam int CFG_IW  = 8;           // config index width
  localparam int CFG_DW  = 64;          // config data width
  localparam int NORM_LAT = 3;
  localparam int MUL_LAT = 1 + NORM_LAT;
  localparam int ADD_LAT = 2 + NORM_LAT;
  localparam int LAT     = MUL_LAT + 3 * ADD_LAT;

  localparam logic [FW-1:0] QNAN = 32'h7FC0_0000;

  typedef logic [FW-1:0] f32_t;

  // Unpacked operand: effective exponent (subnormal reads as 1), hidden bit in man.
  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        zero;
    logic        sign;
    logic [7:0]  exp;
    logic [23:0] man;
  } m4v_fp_t;

  // Request into the normaliser: value = sig * 2^q, or spec_bits when spec set.
  typedef struct packed {
    logic                 spec;
    f32_t                 spec_bits;
    logic                 sign;
    logic signed [EW-1:0] q;
    logic [NW-1:0]        sig;
  } m4v_norm_in_t;

  function automatic m4v_fp_t fp_unpack(input f32_t b);
    m4v_fp_t u;
    u.sign = b[31];
    u.nan  = (&b[30:23]) && (|b[22:0]);
    u.inf  = (&b[30:23]) && !(|b[22:0]);
    u.zero = (b[30:0] == 31'd0);
    u.exp  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    u.man  = {|b[30:23], b[22:0]};
    return u;
  endfunction

endpackage

// ===== hdl/m4v_norm.sv =====
// m4v_norm: three-stage normalise and round-to-nearest-even to float32.
// Depends on m4v_pkg.
module m4v_norm import m4v_pkg::*; (
  input  logic         clk,
  input  logic         en,
  input  m4v_norm_in_t d,
  output f32_t         q
);

  localparam logic signed [EW-1:0] BE_OFS  = EW'(NW - 1 + 127);
  localparam logic signed [EW-1:0] SUB_OFS = EW'(149);
  localparam logic signed [EW-1:0] R_MAX   = EW'(NW + 1);

  // stage 1: leading-zero count
  m4v_norm_in_t s1;
  logic [5:0]   lz1;
  logic [5:0]   lz;

  always_comb begin
    lz = '0;
    for (int i = 0; i < NW; i++) begin
      if (d.sig[i]) lz = 6'(NW - 1 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1  <= d;
      lz1 <= lz;
    end
  end

  // stage 2: left shift so the leading one sits at the top
  m4v_norm_in_t s2;

  always_ff @(posedge clk) begin
    if (en) begin
      s2.spec      <= s1.spec;
      s2.spec_bits <= s1.spec_bits;
      s2.sign      <= s1.sign;
      s2.sig       <= s1.sig << lz1;
      s2.q         <= s1.q - $signed(EW'(lz1));
    end
  end

  // stage 3: right shift to 24 bits (or subnormal), round, pack
  logic signed [EW-1:0] be, rs, ebase, field;
  logic                 normal;
  logic [6:0]           r;
  logic [NW+1:0]        ext, mask, half, rem;
  logic [NW-1:0]        kept;
  logic                 rup;
  logic [24:0]          m;
  f32_t                 res;

  always_comb begin
    be     = s2.q + BE_OFS;
    rs     = -(s2.q + SUB_OFS);
    normal = (be > 0);
    if (normal) begin
      r = 7'(NW - 24);
    end else if (rs > R_MAX) begin
      r = 7'(NW + 1);
    end else begin
      r = rs[6:0];
    end
    ext   = {2'b00, s2.sig};
    mask  = ((NW + 2)'(1) << r) - (NW + 2)'(1);
    half  = (NW + 2)'(1) << (r - 7'd1);
    rem   = ext & mask;
    kept  = s2.sig >> r;
    rup   = (rem > half) || ((rem == half) && kept[0]);
    m     = {1'b0, kept[23:0]} + 25'(rup);
    ebase = normal ? (be - EW'(1)) : '0;
    field = ebase + $signed(EW'(m[24:23]));
    if (s2.spec) begin
      res = s2.spec_bits;
    end else if (field >= EW'(255)) begin
      res = {s2.sign, 8'hFF, 23'd0};
    end else begin
      res = {s2.sign, field[7:0], m[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= res;
  end

endmodule

// ===== hdl/m4v_fmul.sv =====
// m4v_fmul: float32 multiplier, significand product stage then m4v_norm.
// Depends on m4v_pkg and m4v_norm.
module m4v_fmul import m4v_pkg::*; (
  input  logic clk,
  input  logic en,
  input  f32_t a,
  input  f32_t b,
  output f32_t q
);

  m4v_fp_t      ua, ub;
  m4v_norm_in_t nx, nr;
  logic         sg;

  always_comb begin
    ua = fp_unpack(a);
    ub = fp_unpack(b);
    sg = ua.sign ^ ub.sign;
    nx.sign      = sg;
    nx.sig       = NW'(ua.man * ub.man);
    nx.q         = $signed(EW'(ua.exp)) + $signed(EW'(ub.exp)) - EW'(300);
    nx.spec      = 1'b1;
    if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
      nx.spec_bits = QNAN;
    end else if (ua.inf || ub.inf) begin
      nx.spec_bits = {sg, 8'hFF, 23'd0};
    end else if (ua.zero || ub.zero) begin
      nx.spec_bits = {sg, 31'd0};
    end else begin
      nx.spec      = 1'b0;
      nx.spec_bits = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) nr <= nx;
  end

  m4v_norm u_norm (
    .clk (clk),
    .en  (en),
    .d   (nr),
    .q   (q)
  );

endmodule

// ===== hdl/m4v_fadd.sv =====
// m4v_fadd: float32 adder: align stage, add stage, then m4v_norm.
// Depends on m4v_pkg and m4v_norm.
module m4v_fadd import m4v_pkg::*; (
  input  logic clk,
  input  logic en,
  input  f32_t a,
  input  f32_t b,
  output f32_t q
);

  m4v_fp_t ua, ub, ul, us;
  logic    swap;
  logic [7:0]  dexp;
  logic [26:0] bext, bsh;
  logic        stk;

  // aligned operands, larger magnitude first
  logic        al_spec;
  f32_t        al_bits;
  logic        al_sign, al_sub, al_zsign;
  logic [7:0]  al_exp;
  logic [26:0] al_a, al_b;
  logic        spec;
  f32_t        sbits;

  always_comb begin
    ua   = fp_unpack(a);
    ub   = fp_unpack(b);
    swap = (ub.exp > ua.exp) || ((ub.exp == ua.exp) && (ub.man > ua.man));
    ul   = swap ? ub : ua;
    us   = swap ? ua : ub;
    dexp = ul.exp - us.exp;
    bext = {us.man, 3'b000};
    if (dexp >= 8'd27) begin
      bsh = '0;
      stk = |us.man;
    end else begin
      bsh = bext >> dexp;
      stk = |(bext & ((27'd1 << dexp) - 27'd1));
    end
    spec = 1'b1;
    if (ua.nan || ub.nan || (ua.inf && ub.inf && (ua.sign != ub.sign))) begin
      sbits = QNAN;
    end else if (ua.inf) begin
      sbits = {ua.sign, 8'hFF, 23'd0};
    end else if (ub.inf) begin
      sbits = {ub.sign, 8'hFF, 23'd0};
    end else begin
      spec  = 1'b0;
      sbits = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      al_spec  <= spec;
      al_bits  <= sbits;
      al_sign  <= ul.sign;
      al_sub   <= ua.sign ^ ub.sign;
      al_zsign <= ua.sign & ub.sign;
      al_exp   <= ul.exp;
      al_a     <= {ul.man, 3'b000};
      al_b     <= {bsh[26:1], bsh[0] | stk};
    end
  end

  // add / subtract; exact zero goes out as a special
  logic [27:0]  sum;
  m4v_norm_in_t nx, nr;

  always_comb begin
    sum = al_sub ? ({1'b0, al_a} - {1'b0, al_b}) : ({1'b0, al_a} + {1'b0, al_b});
    nx.sign      = al_sign;
    nx.sig       = {sum, 20'd0};
    nx.q         = $signed(EW'(al_exp)) - EW'(173);
    nx.spec      = al_spec;
    nx.spec_bits = al_bits;
    if (!al_spec && (sum == 28'd0)) begin
      nx.spec      = 1'b1;
      nx.spec_bits = {al_zsign, 31'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) nr <= nx;
  end

  m4v_norm u_norm (
    .clk (clk),
    .en  (en),
    .d   (nr),
    .q   (q)
  );

endmodule

// ===== hdl/mat4_vec4_transform.sv =====
// mat4_vec4_transform: 4x4 float32 matrix times vector, one vertex a cycle while the output is not held.
// Datapath: a multiply, then three chained adds per row.
// Throughput: one request per cycle; the whole pipe holds while a result waits.
// Reset: synchronous, clears the pipe valid bits and loads the identity matrix.
// Depends on m4v_pkg, m4v_fmul, m4v_fadd.
module mat4_vec4_transform import m4v_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       in_x,
  input  logic [31:0]       in_y,
  input  logic [31:0]       in_z,
  input  logic [31:0]       in_w,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_x,
  output logic [31:0]       out_y,
  output logic [31:0]       out_z,
  output logic [31:0]       out_w
);

  // Matrix registers, two entries each, row by row.
  logic [CFG_DW-1:0] mreg [NREG];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mreg[0] <= 64'h0000_0000_3F80_0000;
      mreg[1] <= 64'h0;
      mreg[2] <= 64'h3F80_0000_0000_0000;
      mreg[3] <= 64'h0;
      mreg[4] <= 64'h0;
      mreg[5] <= 64'h0000_0000_3F80_0000;
      mreg[6] <= 64'h0;
      mreg[7] <= 64'h3F80_0000_0000_0000;
    end else if (cfg_valid && (cfg_index < CFG_IW'(NREG))) begin
      mreg[cfg_index[2:0]] <= cfg_data;
    end
  end

  // Global pipe enable: every stage moves unless the output register is held.
  logic           en;
  logic [LAT-1:0] vld;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  f32_t vin [4];
  f32_t res [4];

  assign vin[0] = in_x;
  assign vin[1] = in_y;
  assign vin[2] = in_z;
  assign vin[3] = in_w;

  for (genvar r = 0; r < 4; r++) begin : g_row
    f32_t prod [4];
    f32_t d2 [ADD_LAT];      // column 2 product waits for the first add
    f32_t d3 [2 * ADD_LAT];  // column 3 product waits for two adds
    f32_t s1, s2;

    for (genvar c = 0; c < 4; c++) begin : g_col
      m4v_fmul u_mul (
        .clk (clk),
        .en  (en),
        .a   (mreg[r * 2 + c / 2][(c % 2) * 32 +: 32]),
        .b   (vin[c]),
        .q   (prod[c])
      );
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d2[0] <= prod[2];
        for (int k = 1; k < ADD_LAT; k++) d2[k] <= d2[k-1];
        d3[0] <= prod[3];
        for (int k = 1; k < 2 * ADD_LAT; k++) d3[k] <= d3[k-1];
      end
    end

    // left to right: ((p0 + p1) + p2) + p3
    m4v_fadd u_add0 (.clk(clk), .en(en), .a(prod[0]), .b(prod[1]),           .q(s1));
    m4v_fadd u_add1 (.clk(clk), .en(en), .a(s1),      .b(d2[ADD_LAT-1]),     .q(s2));
    m4v_fadd u_add2 (.clk(clk), .en(en), .a(s2),      .b(d3[2*ADD_LAT-1]),   .q(res[r]));
  end

  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];
  assign out_w = res[3];

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking bench for mat4_vec4_transform (4x4 float32 matrix by vector).
// Depends on m4v_pkg and the RTL top; the float32 predictor is built in, in integer terms.
module tb_top;
  import m4v_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE       = LAT + 6;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [31:0]       in_x = '0, in_y = '0, in_z = '0, in_w = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [31:0]       out_x, out_y, out_z, out_w;

  typedef struct packed {
    f32_t x, y, z, w;
  } vec4_t;

  vec4_t       vertex_q[$];     // requests waiting to be driven
  vec4_t       transformed_q[$]; // predicted results, oldest first
  logic [63:0] matrix_regs[NREG];
  int          cycle_cnt = 0;
  int          errors = 0;

  mat4_vec4_transform dut (.*);

  always #4 clk = ~clk;

  // Random back-pressure on both sides, none at all in a calm window mid-run.
  function automatic bit take_gap();
    if (cycle_cnt > 2500 && cycle_cnt < 4500) return 1'b0;
    return $urandom_range(99) < 9;
  endfunction

  // ---------------------------------------------------------------------------
  // Float32 predictor. Values are carried exactly as sig * 2^e and only
  // rounded once, so each product and each partial sum rounds like the
  // hardware: round to nearest even, subnormals kept, overflow to infinity.
  // ---------------------------------------------------------------------------
  function automatic bit is_nan(f32_t b);
    return (&b[30:23]) && (|b[22:0]);
  endfunction

  function automatic bit is_inf(f32_t b);
    return (&b[30:23]) && !(|b[22:0]);
  endfunction

  function automatic logic [319:0] sig_of(f32_t b);
    return (b[30:23] == 8'd0) ? {297'd0, b[22:0]} : {296'd0, 1'b1, b[22:0]};
  endfunction

  // weight of the lowest significand bit
  function automatic int lsb_exp_of(f32_t b);
    return (b[30:23] == 8'd0) ? -149 : int'(b[30:23]) - 150;
  endfunction

  function automatic f32_t round_to_f32(logic s, int e, logic [319:0] m);
    int           msb;
    int           lsb;
    int           sh;
    int           bexp;
    logic [319:0] kept;
    logic         rb;
    logic         sticky;
    msb = 0;
    for (int i = 319; i >= 0; i--) begin
      if (m[i]) begin
        msb = i;
        break;
      end
    end
    lsb = (msb + e - 23 > -149) ? msb + e - 23 : -149;
    sh  = lsb - e;
    if (sh <= 0) begin
      kept = m << (-sh);
    end else begin
      rb     = m[sh-1];
      sticky = |(m & ((320'd1 << (sh - 1)) - 320'd1));
      kept   = m >> sh;
      if (rb && (sticky || kept[0])) kept = kept + 320'd1;
    end
    if (kept[24]) begin
      kept = kept >> 1;
      lsb++;
    end
    if (kept[23]) begin
      bexp = lsb + 150;
      if (bexp >= 255) return {s, 8'hFF, 23'd0};
      return {s, bexp[7:0], kept[22:0]};
    end
    return {s, 8'd0, kept[22:0]};
  endfunction

  function automatic f32_t fp_mul(f32_t a, f32_t b);
    logic s;
    logic a_zero;
    logic b_zero;
    s      = a[31] ^ b[31];
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    if (is_nan(a) || is_nan(b)) return QNAN;
    if ((is_inf(a) && b_zero) || (is_inf(b) && a_zero)) return QNAN;
    if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
    if (a_zero || b_zero) return {s, 31'd0};
    return round_to_f32(s, lsb_exp_of(a) + lsb_exp_of(b), sig_of(a) * sig_of(b));
  endfunction

  function automatic f32_t fp_add(f32_t a, f32_t b);
    int           ea;
    int           eb;
    int           e;
    logic [319:0] ma;
    logic [319:0] mb;
    logic [319:0] sum;
    logic         s;
    if (is_nan(a) || is_nan(b)) return QNAN;
    if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : QNAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
    ea = lsb_exp_of(a);
    eb = lsb_exp_of(b);
    e  = (ea < eb) ? ea : eb;
    ma = sig_of(a) << (ea - e);
    mb = sig_of(b) << (eb - e);
    if (a[31] == b[31]) begin
      sum = ma + mb;
      s   = a[31];
    end else if (ma >= mb) begin
      sum = ma - mb;
      s   = a[31];
    end else begin
      sum = mb - ma;
      s   = b[31];
    end
    if (sum == '0) return 32'd0;   // exact cancellation gives +0 under RNE
    return round_to_f32(s, e, sum);
  endfunction

  function automatic f32_t matrix_entry(int r, int c);
    logic [63:0] rg;
    rg = matrix_regs[r * 2 + c / 2];
    return (c % 2 == 1) ? rg[63:32] : rg[31:0];
  endfunction

  function automatic f32_t row_times(int r, vec4_t v);
    f32_t acc;
    acc = fp_add(fp_mul(matrix_entry(r, 0), v.x), fp_mul(matrix_entry(r, 1), v.y));
    acc = fp_add(acc, fp_mul(matrix_entry(r, 2), v.z));
    return fp_add(acc, fp_mul(matrix_entry(r, 3), v.w));
  endfunction

  function automatic vec4_t transform(vec4_t v);
    vec4_t res;
    res.x = row_times(0, v);
    res.y = row_times(1, v);
    res.z = row_times(2, v);
    res.w = row_times(3, v);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus values: specials, fully random patterns, zero-exponent patterns
  // and mid-range numbers so that partial sums actually interact.
  // ---------------------------------------------------------------------------
  function automatic f32_t pick_f32();
    f32_t specials[12] = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                           32'h7F80_0000, 32'hFF80_0000, 32'h7FFF_FFFF, 32'h7F7F_FFFF,
                           32'h0000_0001, 32'h807F_FFFF, 32'h0080_0000, 32'hFFC0_0001};
    f32_t v;
    v = $urandom;
    case ($urandom_range(9))
      0:       v = specials[$urandom_range(11)];
      1, 2:    ;
      3:       v[30:23] = 8'd0;
      default: v[30:23] = 8'($urandom_range(112, 142));
    endcase
    return v;
  endfunction

  // Directed requests: field extremes and the IEEE corner cases.
  function automatic void queue_corners();
    vertex_q.push_back('{32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000});
    vertex_q.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    vertex_q.push_back('{32'h3F80_0000, 32'hBF80_0000, 32'h4000_0000, 32'hC000_0000});
    vertex_q.push_back('{32'h7F80_0000, 32'hFF80_0000, 32'h0000_0000, 32'h3F80_0000});
    vertex_q.push_back('{32'h7F80_0000, 32'h7F80_0000, 32'h7F80_0000, 32'h7F80_0000});
    vertex_q.push_back('{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7F80_0001, 32'hFFC0_0000});
    vertex_q.push_back('{32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F7F_FFFF});
    vertex_q.push_back('{32'h0000_0001, 32'h8000_0001, 32'h007F_FFFF, 32'h0080_0000});
    vertex_q.push_back('{32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001});
    vertex_q.push_back('{32'h007F_FFFF, 32'h0000_0001, 32'h807F_FFFF, 32'h0080_0000});
    vertex_q.push_back('{32'h3F80_0000, 32'h3380_0000, 32'h3380_0000, 32'h3380_0000});
    vertex_q.push_back('{32'h4B80_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h3F00_0000});
    vertex_q.push_back('{32'h2000_0000, 32'h1000_0000, 32'h0F00_0000, 32'h6000_0000});
    vertex_q.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    vertex_q.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC});
  endfunction

  function automatic void queue_random(int n);
    for (int i = 0; i < n; i++)
      vertex_q.push_back('{pick_f32(), pick_f32(), pick_f32(), pick_f32()});
  endfunction

  // ---------------------------------------------------------------------------
  // Config writes: only issued while the pipe is empty. Out-of-range indexes
  // must be dropped, so the shadow copy ignores them too.
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [63:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NREG) matrix_regs[idx] = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic load_matrix(input logic [63:0] m[NREG]);
    for (int i = 0; i < NREG; i++) write_reg(CFG_IW'(i), m[i]);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (vertex_q.size() != 0 || in_valid || transformed_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Driver: fresh request when the previous one went or none was pending.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        transformed_q.push_back(transform('{in_x, in_y, in_z, in_w}));
      if (!in_valid || in_ready) begin
        if (vertex_q.size() != 0 && !take_gap()) begin
          vec4_t v;
          v = vertex_q.pop_front();
          in_x     <= v.x;
          in_y     <= v.y;
          in_z     <= v.z;
          in_w     <= v.w;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (transformed_q.size() == 0) begin
          $display("%0t: result with none pending: %h %h %h %h",
                   $time, out_x, out_y, out_z, out_w);
          errors++;
        end else begin
          vec4_t exp_v;
          exp_v = transformed_q.pop_front();
          if (out_x !== exp_v.x) begin
            $display("%0t: out_x expected %h actual %h", $time, exp_v.x, out_x);
            errors++;
          end
          if (out_y !== exp_v.y) begin
            $display("%0t: out_y expected %h actual %h", $time, exp_v.y, out_y);
            errors++;
          end
          if (out_z !== exp_v.z) begin
            $display("%0t: out_z expected %h actual %h", $time, exp_v.z, out_z);
            errors++;
          end
          if (out_w !== exp_v.w) begin
            $display("%0t: out_w expected %h actual %h", $time, exp_v.w, out_w);
            errors++;
          end
        end
      end
      out_ready <= !take_gap();
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    logic [63:0] m[NREG];
    matrix_regs = '{64'h0000_0000_3F80_0000, 64'd0, 64'h3F80_0000_0000_0000, 64'd0,
                    64'd0, 64'h0000_0000_3F80_0000, 64'd0, 64'h3F80_0000_0000_0000};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // identity after reset: the corner requests run through the reset matrix (0 * inf gives NaN)
    queue_corners();
    wait_drained();

    // all-ones matrix: every row sums the vector, so inf-inf and overflow show up
    for (int i = 0; i < NREG; i++) m[i] = 64'h3F80_0000_3F80_0000;
    load_matrix(m);
    queue_corners();
    queue_random(150);
    wait_drained();

    // extremes of the register range: all zero, then all ones (NaN everywhere)
    for (int i = 0; i < NREG; i++) m[i] = 64'd0;
    load_matrix(m);
    queue_random(100);
    wait_drained();
    for (int i = 0; i < NREG; i++) m[i] = '1;
    load_matrix(m);
    queue_random(60);
    wait_drained();

    // random matrices; a stray write past the last register must change nothing
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < NREG; i++) m[i] = {pick_f32(), pick_f32()};
      load_matrix(m);
      write_reg(CFG_IW'($urandom_range(NREG, (1 << CFG_IW) - 1)), {$urandom, $urandom});
      queue_random(260);
      wait_drained();
    end

    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/m4v_pkg.sv
hdl/m4v_norm.sv
hdl/m4v_fmul.sv
hdl/m4v_fadd.sv
hdl/mat4_vec4_transform.sv
dv/tb_top.sv
